// ----- hdl/tfsp_pkg.sv -----
`default_nettype none

package tfsp_pkg;

    localparam int unsigned BLOCK_W = 32;
    localparam int unsigned HALF_W  = 16;

    localparam int unsigned ROT_A = 2;
    localparam int unsigned ROT_B = 8;
    localparam int unsigned ROT_C = 11;
    localparam int unsigned ROT_D = 1;

    typedef logic [3:0] nibble_t;
    typedef logic [4:0] bit_idx_t;

    localparam nibble_t SBOX4 [16] = '{
        4'd3, 4'd9, 4'd15, 4'd10, 4'd5, 4'd11, 4'd13, 4'd2,
        4'd6, 4'd4, 4'd12, 4'd0, 4'd14, 4'd7, 4'd1, 4'd8
    };

    localparam nibble_t PERM16 [16] = '{
        4'd1, 4'd10, 4'd3, 4'd12, 4'd5, 4'd14, 4'd7, 4'd0,
        4'd9, 4'd2, 4'd11, 4'd4, 4'd13, 4'd6, 4'd15, 4'd8
    };

    localparam bit_idx_t PERM32 [32] = '{
        5'd17, 5'd10, 5'd3, 5'd28, 5'd21, 5'd14, 5'd7, 5'd0,
        5'd25, 5'd18, 5'd11, 5'd4, 5'd29, 5'd22, 5'd15, 5'd8,
        5'd1, 5'd26, 5'd19, 5'd12, 5'd5, 5'd30, 5'd23, 5'd16,
        5'd9, 5'd2, 5'd27, 5'd20, 5'd13, 5'd6, 5'd31, 5'd24
    };

    typedef struct packed {
        logic [HALF_W-1:0]  k16a;
        logic [HALF_W-1:0]  k16b;
        logic [HALF_W-1:0]  k16c;
        logic [BLOCK_W-1:0] k32a;
        logic [BLOCK_W-1:0] k32b;
    } round_keys_t;

    function automatic logic [HALF_W-1:0] rol16(input logic [HALF_W-1:0] v,
                                                input int unsigned n);
        return (v << n) | (v >> (HALF_W - n));
    endfunction

    function automatic logic [HALF_W-1:0] sp16(input logic [HALF_W-1:0] x,
                                               input logic [HALF_W-1:0] k);
        logic [HALF_W-1:0] t;
        logic [HALF_W-1:0] s;
        logic [HALF_W-1:0] y;
        t = x ^ k;
        for (int i = 0; i < HALF_W / 4; i++)
        begin
            s[i*4 +: 4] = SBOX4[t[i*4 +: 4]];
        end
        y = '0;
        for (int i = 0; i < HALF_W; i++)
        begin
            y[PERM16[i]] = s[i];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] sp32(input logic [BLOCK_W-1:0] x,
                                                input logic [BLOCK_W-1:0] k);
        logic [BLOCK_W-1:0] t;
        logic [BLOCK_W-1:0] s;
        logic [BLOCK_W-1:0] y;
        t = x ^ k;
        for (int i = 0; i < BLOCK_W / 4; i++)
        begin
            s[i*4 +: 4] = SBOX4[t[i*4 +: 4]];
        end
        y = '0;
        for (int i = 0; i < BLOCK_W; i++)
        begin
            y[PERM32[i]] = s[i];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] feistel(input logic [BLOCK_W-1:0] x,
                                                   input logic [HALF_W-1:0] k);
        return {x[HALF_W-1:0], x[BLOCK_W-1:HALF_W] ^ sp16(x[HALF_W-1:0], k)};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/tfsp_key_sched.sv -----
`default_nettype none

module tfsp_key_sched
    import tfsp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    input  wire logic [BLOCK_W-1:0] cfg_data,
    output round_keys_t             keys
);

    logic [BLOCK_W-1:0] key_reg;
    logic [BLOCK_W-1:0] key_next;
    logic [HALF_W-1:0]  hi;
    logic [HALF_W-1:0]  lo;

    assign key_next = cfg_valid ? cfg_data : key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else
        begin
            key_reg <= key_next;
        end
    end

    assign hi = key_reg[BLOCK_W-1:HALF_W];
    assign lo = key_reg[HALF_W-1:0];

    always_comb
    begin
        keys.k16a = hi & rol16(lo, ROT_A);
        keys.k16b = rol16(lo, ROT_B);
        keys.k16c = lo;
        keys.k32a = {rol16(lo, ROT_C), rol16(hi, ROT_A)};
        keys.k32b = {rol16(lo, ROT_D), lo};
    end

endmodule

`default_nettype wire

// ----- hdl/tfsp_rounds.sv -----
`default_nettype none

module tfsp_rounds
    import tfsp_pkg::*;
(
    input  wire logic [BLOCK_W-1:0] din,
    input  wire round_keys_t        keys,
    output logic [BLOCK_W-1:0]      dout
);

    logic [BLOCK_W-1:0] r1;
    logic [BLOCK_W-1:0] r2;
    logic [BLOCK_W-1:0] r3;
    logic [BLOCK_W-1:0] r4;
    logic [BLOCK_W-1:0] r5;

    assign r1   = feistel(din, keys.k16a);
    assign r2   = sp32(r1, keys.k32a);
    assign r3   = feistel(r2, keys.k16b);
    assign r4   = {r3[HALF_W-1:0], r3[BLOCK_W-1:HALF_W]};
    assign r5   = feistel(r4, keys.k16c);
    assign dout = r5 ^ keys.k32b;

endmodule

`default_nettype wire

// ----- hdl/toy_feistel_sp_block_encrypt_core.sv -----
// Toy Feistel/SP block encrypt core, one 32-bit block per word.
//
// Key channel: cfg_data is written into the key register on a clock edge
// with cfg_valid high; cfg_ready is always high. Write the key only while
// no block is in flight.
// Block channel: a word is taken on an edge with start high and busy low.
// busy stays low, so a new block can be taken on every cycle.
// Result: cipher_block is shown for one cycle with done high, after the
// block has passed the input register and then the result register.
// Throughput is one block per cycle; each block passes through the input
// and result registers around the single-pass round logic.
// The receiver cannot stall: each result must be taken while done is high.
// Reset clears the key to zero and drops all in-flight words.
`default_nettype none

module toy_feistel_sp_block_encrypt_core
    import tfsp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [BLOCK_W-1:0] plain_block,
    output logic                    done,
    output logic [BLOCK_W-1:0]      cipher_block,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [BLOCK_W-1:0] cfg_data
);

    round_keys_t        keys;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic [BLOCK_W-1:0] in_data_reg;
    logic [BLOCK_W-1:0] in_data_next;
    logic               out_valid_reg;
    logic [BLOCK_W-1:0] out_data_reg;
    logic [BLOCK_W-1:0] out_data_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    tfsp_key_sched u_key_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .keys      (keys)
    );

    tfsp_rounds u_rounds (
        .din  (in_data_reg),
        .keys (keys),
        .dout (out_data_next)
    );

    assign in_valid_next = start && !busy;
    assign in_data_next  = in_valid_next ? plain_block : in_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign done         = out_valid_reg;
    assign cipher_block = out_data_reg;

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> in_valid_reg)
        else $error("accepted word not captured");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |=> done)
        else $error("captured word produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |=> !done)
        else $error("result without captured word");

    a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("latency is not two cycles");

endmodule

`default_nettype wire
